[rtl/core/u16u8_pkg.sv]
`default_nettype none

package u16u8_pkg;

  // Default sizes handed to the top level parameters.
  localparam int CNT_BITS_DEF    = 16;
  localparam int QUEUE_DEPTH_DEF = 4;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_CAPACITY = 2'd1;

  // Source encodings.
  localparam logic [1:0] MODE_UTF16LE = 2'd0;
  localparam logic [1:0] MODE_UTF16BE = 2'd1;
  localparam logic [1:0] MODE_LATIN1  = 2'd2;
  localparam logic [1:0] MODE_INVALID = 2'd3;

  localparam logic [15:0] CAPACITY_RESET = 16'd256;

  // Surrogate tags sit in the top six bits of a UTF-16 unit.
  localparam logic [5:0]  SURR_HIGH_TAG = 6'b110110;
  localparam logic [5:0]  SURR_LOW_TAG  = 6'b110111;
  localparam logic [15:0] SURR_BASE     = 16'hD800;
  localparam logic [20:0] SUPP_BASE     = 21'h10000;

  // Input word.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_word_t;

  // Result word.
  typedef struct packed {
    logic [7:0]  out_byte;
    logic        out_stored;
    logic        out_last;
    logic [15:0] out_length;
  } out_word_t;

  // Work handed from the front to the back: up to two code points and an end result.
  typedef struct packed {
    logic [20:0] cp_a;
    logic [2:0]  len_a;
    logic [20:0] cp_b;
    logic [2:0]  len_b;
    logic        end_en;
    logic        end_stored;
    logic [15:0] end_len;
  } job_t;

  // Number of UTF-8 bytes for a code point.
  function automatic logic [2:0] cp_len(input logic [20:0] cp);
    if (cp < 21'h80) begin
      cp_len = 3'd1;
    end else if (cp < 21'h800) begin
      cp_len = 3'd2;
    end else if (cp < 21'h10000) begin
      cp_len = 3'd3;
    end else begin
      cp_len = 3'd4;
    end
  endfunction

  // Byte number idx of the UTF-8 sequence of length len for a code point.
  function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [2:0] len,
                                           input logic [1:0] idx);
    logic [7:0] res;
    res = 8'h00;
    case (len)
      3'd1: res = cp[7:0];
      3'd2: begin
        res = (idx == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
      end
      3'd3: begin
        case (idx)
          2'd0:    res = {4'b1110, cp[15:12]};
          2'd1:    res = {2'b10, cp[11:6]};
          default: res = {2'b10, cp[5:0]};
        endcase
      end
      default: begin
        case (idx)
          2'd0:    res = {5'b11110, cp[20:18]};
          2'd1:    res = {2'b10, cp[17:12]};
          2'd2:    res = {2'b10, cp[11:6]};
          default: res = {2'b10, cp[5:0]};
        endcase
      end
    endcase
    utf8_byte = res;
  endfunction

endpackage

`default_nettype wire

[rtl/core/utf16_latin1_to_utf8_encoder_top.sv]
// The first result word of an input word passes through the job queue, the job
// register and the output register. The front takes one input word per cycle unless
// the job queue is full; the back end sends one result word per cycle if not stalled.
// The job queue between front and back sets how far the front may run ahead.
// Reset (rst_n low, synchronous) empties the queue, clears string state, and sets
// source_mode to UTF-16LE and out_capacity to 256.
`default_nettype none

module utf16_latin1_to_utf8_encoder_top
  import u16u8_pkg::*;
#(
  parameter int COUNT_BITS  = CNT_BITS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire in_word_t             in_word,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output out_word_t                 out_word,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [15:0]          cfg_data
);

  logic queue_full;
  logic job_push;
  job_t job_wr;
  logic job_pop;
  job_t job_rd;
  logic job_valid;

  // Front end: classification and string state.
  u16u8_front #(
    .COUNT_BITS(COUNT_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_word    (in_word),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .queue_full (queue_full),
    .job_push   (job_push),
    .job        (job_wr)
  );

  // Job queue.
  u16u8_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (job_push),
    .wr_data   (job_wr),
    .full      (queue_full),
    .rd_en     (job_pop),
    .rd_data   (job_rd),
    .not_empty (job_valid)
  );

  // Back end: UTF-8 byte serializer.
  u16u8_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (job_valid),
    .job_in    (job_rd),
    .job_pop   (job_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

`default_nettype wire

[rtl/core/u16u8_fifo.sv]
`default_nettype none

module u16u8_fifo
  import u16u8_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic wr_en,
  input  wire job_t wr_data,
  output logic      full,
  input  wire logic rd_en,
  output job_t      rd_data,
  output logic      not_empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  job_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign rd_data   = mem_r[rd_ptr_r];

  // Pointers wrap at the depth, which need not be a power of two.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (wr_en && !rd_en) begin
      count_nxt = count_r + 1'b1;
    end else if (!wr_en && rd_en) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage holds payload only.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

[rtl/core/u16u8_front.sv]
`default_nettype none

module u16u8_front
  import u16u8_pkg::*;
#(
  parameter int COUNT_BITS = CNT_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire in_word_t             in_word,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [15:0]          cfg_data,
  input  wire logic                 queue_full,
  output logic                      job_push,
  output job_t                      job
);

  localparam int CMP_W = ((COUNT_BITS > 16) ? COUNT_BITS : 16) + 1;

  logic [1:0]            mode_r;
  logic [15:0]           cap_r;
  logic [7:0]            held_r, held_nxt;
  logic                  half_r, half_nxt;
  logic [9:0]            phb_r, phb_nxt;
  logic                  phv_r, phv_nxt;
  logic [COUNT_BITS-1:0] wc_r, wc_nxt;
  logic                  stopped_r, stopped_nxt;
  logic                  push;
  logic                  accept;

  // True when a code point of len bytes still leaves room for the terminator.
  function automatic logic fits(input logic [COUNT_BITS-1:0] w, input logic [2:0] len,
                                input logic [15:0] cap);
    fits = (CMP_W'(w) + CMP_W'(len)) < CMP_W'(cap);
  endfunction

  assign cfg_ready = 1'b1;
  assign in_stall  = queue_full;
  assign accept    = in_valid && !in_stall;
  assign job_push  = accept && push;

  // Classify one source byte into code points, an end result and the next string state.
  always_comb begin
    logic [15:0]           u;
    logic [20:0]           cp;
    logic [2:0]            k;
    logic [COUNT_BITS-1:0] wc;
    logic                  ok;
    logic                  go;
    job         = '0;
    push        = 1'b0;
    held_nxt    = held_r;
    half_nxt    = half_r;
    phb_nxt     = phb_r;
    phv_nxt     = phv_r;
    wc_nxt      = wc_r;
    stopped_nxt = stopped_r;
    wc          = wc_r;
    ok          = 1'b1;
    go          = 1'b1;
    u           = '0;
    cp          = '0;
    k           = '0;
    if (stopped_r) begin
      // Swallow the rest of a stopped string.
      if (in_word.in_last) begin
        held_nxt    = '0;
        half_nxt    = 1'b0;
        phb_nxt     = '0;
        phv_nxt     = 1'b0;
        wc_nxt      = '0;
        stopped_nxt = 1'b0;
      end
    end else if (mode_r == MODE_INVALID) begin
      job.end_en = 1'b1;
      push       = 1'b1;
      if (in_word.in_last) begin
        held_nxt = '0;
        half_nxt = 1'b0;
        phb_nxt  = '0;
        phv_nxt  = 1'b0;
        wc_nxt   = '0;
      end else begin
        // Unit state is never looked at again before the last byte clears it.
        stopped_nxt = 1'b1;
        half_nxt    = 1'b0;
        phv_nxt     = 1'b0;
      end
    end else begin
      if (mode_r == MODE_LATIN1) begin
        half_nxt = 1'b0;
        phv_nxt  = 1'b0;
        cp       = {13'd0, in_word.in_byte};
        k        = cp_len(cp);
        if (in_word.in_byte == 8'd0 || !fits(wc, k, cap_r)) begin
          ok = 1'b0;
        end else begin
          job.cp_a  = cp;
          job.len_a = k;
          wc        = wc + COUNT_BITS'(k);
        end
      end else if (!half_r) begin
        if (in_word.in_last) begin
          // A lone trailing byte is dropped; a held high surrogate is flushed.
          if (phv_r) begin
            phv_nxt = 1'b0;
            cp      = {5'd0, SURR_BASE | {6'd0, phb_r}};
            if (fits(wc, 3'd3, cap_r)) begin
              job.cp_a  = cp;
              job.len_a = 3'd3;
              wc        = wc + COUNT_BITS'(3);
            end else begin
              ok = 1'b0;
            end
          end
        end else begin
          held_nxt = in_word.in_byte;
          half_nxt = 1'b1;
        end
      end else begin
        u        = (mode_r == MODE_UTF16LE) ? {in_word.in_byte, held_r}
                                            : {held_r, in_word.in_byte};
        half_nxt = 1'b0;
        // Resolve a pending high surrogate first.
        if (phv_r) begin
          phv_nxt = 1'b0;
          if (u[15:10] == SURR_LOW_TAG) begin
            go = 1'b0;
            cp = SUPP_BASE + {1'b0, phb_r, u[9:0]};
            if (fits(wc, 3'd4, cap_r)) begin
              job.cp_a  = cp;
              job.len_a = 3'd4;
              wc        = wc + COUNT_BITS'(4);
            end else begin
              ok = 1'b0;
            end
          end else begin
            cp = {5'd0, SURR_BASE | {6'd0, phb_r}};
            if (fits(wc, 3'd3, cap_r)) begin
              job.cp_a  = cp;
              job.len_a = 3'd3;
              wc        = wc + COUNT_BITS'(3);
            end else begin
              ok = 1'b0;
              go = 1'b0;
            end
          end
        end
        // Then the unit itself.
        if (go) begin
          if (u[15:10] == SURR_HIGH_TAG && !in_word.in_last) begin
            phb_nxt = u[9:0];
            phv_nxt = 1'b1;
          end else if (u == 16'd0) begin
            ok = 1'b0;
          end else begin
            k = cp_len({5'd0, u});
            if (fits(wc, k, cap_r)) begin
              job.cp_b  = {5'd0, u};
              job.len_b = k;
              wc        = wc + COUNT_BITS'(k);
            end else begin
              ok = 1'b0;
            end
          end
        end
      end
      // Close the string on a stop or on its last byte.
      wc_nxt = wc;
      if (!ok || in_word.in_last) begin
        job.end_en     = 1'b1;
        job.end_stored = (cap_r != 16'd0);
        job.end_len    = 16'(wc);
        if (in_word.in_last) begin
          held_nxt = '0;
          half_nxt = 1'b0;
          phb_nxt  = '0;
          phv_nxt  = 1'b0;
          wc_nxt   = '0;
        end else begin
          stopped_nxt = 1'b1;
          half_nxt    = 1'b0;
          phv_nxt     = 1'b0;
        end
      end
      push = job.end_en || (job.len_a != 3'd0) || (job.len_b != 3'd0);
    end
  end

  // String state advances on each accepted word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r    <= '0;
      half_r    <= 1'b0;
      phb_r     <= '0;
      phv_r     <= 1'b0;
      wc_r      <= '0;
      stopped_r <= 1'b0;
    end else if (accept) begin
      held_r    <= held_nxt;
      half_r    <= half_nxt;
      phb_r     <= phb_nxt;
      phv_r     <= phv_nxt;
      wc_r      <= wc_nxt;
      stopped_r <= stopped_nxt;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_UTF16LE;
      cap_r  <= CAPACITY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SOURCE_MODE:  mode_r <= cfg_data[1:0];
        REG_OUT_CAPACITY: cap_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // A stopped string produces no work, not even on its last byte.
  assert property (@(posedge clk) disable iff (!rst_n)
    (accept && stopped_r) |-> !job_push)
    else $error("front pushed work for a stopped string");

  // Work handed on in the invalid mode is a bare, unstored end result.
  assert property (@(posedge clk) disable iff (!rst_n)
    (job_push && mode_r == MODE_INVALID)
      |-> (job.end_en && !job.end_stored && job.len_a == 3'd0 && job.len_b == 3'd0))
    else $error("invalid mode handed on code points");

  // A half unit is never held together with a stopped string.
  assert property (@(posedge clk) disable iff (!rst_n)
    stopped_r |-> (!half_r && !phv_r))
    else $error("stopped string still holds unit state");

endmodule

`default_nettype wire

[rtl/core/u16u8_back.sv]
`default_nettype none

module u16u8_back
  import u16u8_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic job_valid,
  input  wire job_t job_in,
  output logic      job_pop,
  output logic      out_valid,
  input  wire logic out_stall,
  output out_word_t out_word
);

  localparam logic [1:0] SLOT_A   = 2'd0;
  localparam logic [1:0] SLOT_B   = 2'd1;
  localparam logic [1:0] SLOT_END = 2'd2;

  job_t       cur_r;
  logic       busy_r, busy_nxt;
  logic [1:0] slot_r, slot_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       out_valid_r;
  out_word_t  out_word_r, word_nxt;
  logic       out_free;
  logic       emit;
  logic       done;
  logic [2:0] cur_len;
  logic [20:0] cur_cp;
  logic       slot_last;
  logic [1:0] after_slot;
  logic       after_ok;
  logic [1:0] first_slot;

  assign out_free  = !out_valid_r || !out_stall;
  assign emit      = busy_r && out_free;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // Current code point and where the job goes after this slot.
  always_comb begin
    cur_len    = 3'd0;
    cur_cp     = '0;
    after_slot = SLOT_END;
    after_ok   = 1'b0;
    case (slot_r)
      SLOT_A: begin
        cur_len = cur_r.len_a;
        cur_cp  = cur_r.cp_a;
        if (cur_r.len_b != 3'd0) begin
          after_slot = SLOT_B;
          after_ok   = 1'b1;
        end else begin
          after_ok = cur_r.end_en;
        end
      end
      SLOT_B: begin
        cur_len  = cur_r.len_b;
        cur_cp   = cur_r.cp_b;
        after_ok = cur_r.end_en;
      end
      default: ;
    endcase
  end

  assign slot_last = (slot_r == SLOT_END) || ({1'b0, idx_r} + 3'd1 == cur_len);
  assign done      = emit && slot_last && !after_ok;
  assign job_pop   = job_valid && (!busy_r || done);

  assign first_slot = (job_in.len_a != 3'd0) ? SLOT_A :
                      (job_in.len_b != 3'd0) ? SLOT_B : SLOT_END;

  // Result byte for the current position.
  always_comb begin
    word_nxt = '0;
    if (slot_r == SLOT_END) begin
      word_nxt.out_stored = cur_r.end_stored;
      word_nxt.out_last   = 1'b1;
      word_nxt.out_length = cur_r.end_len;
    end else begin
      word_nxt.out_byte   = utf8_byte(cur_cp, cur_len, idx_r);
      word_nxt.out_stored = 1'b1;
    end
  end

  // Walk the bytes of a job, loading the next job as the current one ends.
  always_comb begin
    busy_nxt = busy_r;
    slot_nxt = slot_r;
    idx_nxt  = idx_r;
    if (emit) begin
      if (!slot_last) begin
        idx_nxt = idx_r + 2'd1;
      end else if (after_ok) begin
        slot_nxt = after_slot;
        idx_nxt  = 2'd0;
      end else begin
        busy_nxt = 1'b0;
      end
    end
    if (job_pop) begin
      busy_nxt = 1'b1;
      slot_nxt = first_slot;
      idx_nxt  = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      slot_r      <= SLOT_A;
      idx_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      slot_r <= slot_nxt;
      idx_r  <= idx_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (job_pop) begin
      cur_r <= job_in;
    end
    if (emit) begin
      out_word_r <= word_nxt;
    end
  end

  // The end slot is only reached for jobs that carry an end result.
  assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && slot_r == SLOT_END) |-> cur_r.end_en)
    else $error("end slot reached without an end result");

  // A byte position always lies inside its code point.
  assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && slot_r != SLOT_END) |-> ({1'b0, idx_r} < cur_len))
    else $error("byte index outside code point");

  // A finished job with nothing queued leaves the back end idle.
  assert property (@(posedge clk) disable iff (!rst_n)
    (done && !job_valid) |=> !busy_r)
    else $error("back end stayed busy after its last byte");

  // Every emitted byte shows up as a valid word.
  assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> out_valid_r)
    else $error("emitted byte was lost");

endmodule

`default_nettype wire
